// ===== rtl/core/xeu_pkg.sv =====
package xeu_pkg;

  // default span of a reference, ampersand included
  localparam int unsigned MaxRefSpanDef = 10;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned ResCntW = 3;
  localparam int unsigned ResIdxW = 2;

  localparam logic [CpW-1:0] LastCp = 21'h10FFFF;

  typedef enum logic {
    FaultName    = 1'b0,
    FaultNumeric = 1'b1
  } fault_e;

  // one group of results caused by one input byte
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [ResCntW-1:0]           cnt;
    logic                         is_error;
    fault_e                       fault;
    logic                         done;
  } grp_t;

endpackage

// ===== rtl/core/xeu_if.sv =====
interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_error;
  logic       fault_code;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output is_error, output fault_code,
                  output run_last, output text_done, input ready);
  modport sink (input valid, input out_byte, input is_error, input fault_code,
                input run_last, input text_done, output ready);
endinterface

// ===== rtl/core/xeu_utf8.sv =====
module xeu_utf8 (
  input  logic [xeu_pkg::CpW-1:0]                             cp_i,
  output logic [xeu_pkg::MaxRes-1:0][xeu_pkg::ByteW-1:0]      bytes_o,
  output logic [xeu_pkg::ResCntW-1:0]                         cnt_o
);

  localparam logic [xeu_pkg::CpW-1:0] Lim1 = 21'h80;
  localparam logic [xeu_pkg::CpW-1:0] Lim2 = 21'h800;
  localparam logic [xeu_pkg::CpW-1:0] Lim3 = 21'h10000;
  localparam logic [7:0] Cont  = 8'h80;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;

  always_comb begin
    bytes_o = '0;
    if (cp_i < Lim1) begin
      bytes_o[0] = cp_i[7:0];
      cnt_o      = 3'd1;
    end else if (cp_i < Lim2) begin
      bytes_o[0] = Lead2 | {3'b000, cp_i[10:6]};
      bytes_o[1] = Cont | {2'b00, cp_i[5:0]};
      cnt_o      = 3'd2;
    end else if (cp_i < Lim3) begin
      bytes_o[0] = Lead3 | {4'b0000, cp_i[15:12]};
      bytes_o[1] = Cont | {2'b00, cp_i[11:6]};
      bytes_o[2] = Cont | {2'b00, cp_i[5:0]};
      cnt_o      = 3'd3;
    end else begin
      bytes_o[0] = Lead4 | {5'b00000, cp_i[20:18]};
      bytes_o[1] = Cont | {2'b00, cp_i[17:12]};
      bytes_o[2] = Cont | {2'b00, cp_i[11:6]};
      bytes_o[3] = Cont | {2'b00, cp_i[5:0]};
      cnt_o      = 3'd4;
    end
  end

endmodule

// ===== rtl/core/xeu_core.sv =====
module xeu_core #(
  parameter int unsigned MaxRefSpan = xeu_pkg::MaxRefSpanDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [xeu_pkg::ByteW-1:0] in_byte_i,
  input  logic                      text_last_i,
  output xeu_pkg::grp_t             grp_o
);

  localparam int unsigned NameDepth = MaxRefSpan - 1;
  localparam int unsigned CntW      = $clog2(MaxRefSpan);
  localparam int unsigned HeadLen   = 4;
  localparam int unsigned AccW      = xeu_pkg::CpW + 4;
  localparam logic [CntW-1:0] NameDepthC = CntW'(NameDepth);
  localparam logic [CntW-1:0] HeadLenC   = CntW'(HeadLen);
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLoX  = 8'h78;
  localparam logic [7:0] ChUpX  = 8'h58;

  // {valid, value}
  function automatic logic [4:0] dec_digit(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b0, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    return r;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b0, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic            in_ref_q, in_ref_d;
  logic            err_q, err_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      head_q [HeadLen];
  logic            head_we;
  logic [xeu_pkg::CpW-1:0] dec_q, dec_d, hex_q, hex_d;
  logic            dec_bad_q, dec_bad_d, hex_bad_q, hex_bad_d;

  logic [4:0]      dd, hd;
  logic [AccW-1:0] dec_nx, hex_nx;
  logic            dec_ovf, hex_ovf;
  logic            is_lt, is_gt, is_amp, is_quot, is_apos, is_hex, num_short;
  logic            hash_old, hash_now, fault_hit;
  xeu_pkg::fault_e fault_code;
  logic [xeu_pkg::CpW-1:0] cp_sel;
  logic            bad_sel;
  logic [xeu_pkg::MaxRes-1:0][xeu_pkg::ByteW-1:0] enc_bytes;
  logic [xeu_pkg::ResCntW-1:0] enc_cnt;

  // running digit accumulation, one digit per name byte
  assign dd      = dec_digit(in_byte_i);
  assign hd      = hex_digit(in_byte_i);
  assign dec_nx  = (AccW'(dec_q) << 3) + (AccW'(dec_q) << 1) + AccW'(dd[3:0]);
  assign hex_nx  = (AccW'(hex_q) << 4) + AccW'(hd[3:0]);
  assign dec_ovf = dec_nx > AccW'(xeu_pkg::LastCp);
  assign hex_ovf = hex_nx > AccW'(xeu_pkg::LastCp);

  // name match against the held bytes
  assign is_lt   = (cnt_q == CntW'(2)) && ({head_q[0], head_q[1]} == "lt");
  assign is_gt   = (cnt_q == CntW'(2)) && ({head_q[0], head_q[1]} == "gt");
  assign is_amp  = (cnt_q == CntW'(3)) && ({head_q[0], head_q[1], head_q[2]} == "amp");
  assign is_quot = (cnt_q == CntW'(4)) &&
                   ({head_q[0], head_q[1], head_q[2], head_q[3]} == "quot");
  assign is_apos = (cnt_q == CntW'(4)) &&
                   ({head_q[0], head_q[1], head_q[2], head_q[3]} == "apos");
  assign is_hex  = (cnt_q > CntW'(2)) && (head_q[1] == ChLoX || head_q[1] == ChUpX);
  assign num_short = (cnt_q == CntW'(1));
  assign cp_sel  = is_hex ? hex_q : dec_q;
  assign bad_sel = is_hex ? hex_bad_q : dec_bad_q;

  assign hash_old = (cnt_q != '0) && (head_q[0] == ChHash);
  assign hash_now = (cnt_q == '0) ? (in_byte_i == ChHash) : (head_q[0] == ChHash);

  xeu_utf8 u_utf8 (
    .cp_i    (cp_sel),
    .bytes_o (enc_bytes),
    .cnt_o   (enc_cnt)
  );

  always_comb begin
    in_ref_d   = in_ref_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    dec_d      = dec_q;
    dec_bad_d  = dec_bad_q;
    hex_d      = hex_q;
    hex_bad_d  = hex_bad_q;
    head_we    = 1'b0;
    fault_hit  = 1'b0;
    fault_code = xeu_pkg::FaultName;
    grp_o          = '0;
    grp_o.fault    = xeu_pkg::FaultName;

    if (err_q) begin
      // dropping until end of text
    end else if (!in_ref_q) begin
      if (in_byte_i == ChAmp) begin
        in_ref_d  = 1'b1;
        cnt_d     = '0;
        dec_d     = '0;
        dec_bad_d = 1'b0;
        hex_d     = '0;
        hex_bad_d = 1'b0;
        if (text_last_i) fault_hit = 1'b1;
      end else begin
        grp_o.bytes[0] = in_byte_i;
        grp_o.cnt      = 3'd1;
      end
    end else if (in_byte_i == ChSemi) begin
      in_ref_d = 1'b0;
      cnt_d    = '0;
      if (is_lt || is_gt || is_amp || is_quot || is_apos) begin
        grp_o.cnt = 3'd1;
        if (is_lt)        grp_o.bytes[0] = "<";
        else if (is_gt)   grp_o.bytes[0] = ">";
        else if (is_amp)  grp_o.bytes[0] = "&";
        else if (is_quot) grp_o.bytes[0] = 8'h22;
        else              grp_o.bytes[0] = 8'h27;
      end else if (cnt_q == '0 || head_q[0] != ChHash) begin
        fault_hit = 1'b1;
      end else if (num_short || bad_sel) begin
        fault_hit  = 1'b1;
        fault_code = xeu_pkg::FaultNumeric;
      end else begin
        grp_o.bytes = enc_bytes;
        grp_o.cnt   = enc_cnt;
      end
    end else if (cnt_q >= NameDepthC) begin
      fault_hit  = 1'b1;
      fault_code = hash_old ? xeu_pkg::FaultNumeric : xeu_pkg::FaultName;
    end else begin
      head_we = cnt_q < HeadLenC;
      cnt_d   = cnt_q + CntW'(1);
      if (cnt_q >= CntW'(1)) begin
        dec_bad_d = dec_bad_q | !dd[4] | dec_ovf;
        dec_d     = dec_nx[xeu_pkg::CpW-1:0];
      end
      if (cnt_q >= CntW'(2)) begin
        hex_bad_d = hex_bad_q | !hd[4] | hex_ovf;
        hex_d     = hex_nx[xeu_pkg::CpW-1:0];
      end
      if (text_last_i) begin
        fault_hit  = 1'b1;
        fault_code = hash_now ? xeu_pkg::FaultNumeric : xeu_pkg::FaultName;
      end
    end

    if (fault_hit) begin
      grp_o.bytes    = '0;
      grp_o.cnt      = 3'd1;
      grp_o.is_error = 1'b1;
      grp_o.fault    = fault_code;
      in_ref_d       = 1'b0;
      cnt_d          = '0;
      err_d          = !text_last_i;
    end
    grp_o.done = text_last_i | fault_hit;

    if (text_last_i) begin
      in_ref_d = 1'b0;
      cnt_d    = '0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ref_q <= 1'b0;
      err_q    <= 1'b0;
      cnt_q    <= '0;
    end else if (step_i) begin
      in_ref_q <= in_ref_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dec_q     <= dec_d;
      dec_bad_q <= dec_bad_d;
      hex_q     <= hex_d;
      hex_bad_q <= hex_bad_d;
      if (head_we) head_q[cnt_q[1:0]] <= in_byte_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NameDepthC)
    else $error("name count past buffer depth");

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (!in_ref_q && cnt_q == '0))
    else $error("drop mode while inside a reference");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && err_q) |-> (grp_o.cnt == '0))
    else $error("result produced while dropping");

endmodule

// ===== rtl/core/xeu_outbuf.sv =====
module xeu_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  xeu_pkg::grp_t   grp_i,
  output logic            free_o,
  xeu_out_if.source       out_o
);

  logic                        valid_q;
  logic [xeu_pkg::ResIdxW-1:0] idx_q;
  xeu_pkg::grp_t               grp_q;
  logic                        last_beat;

  assign last_beat = ({1'b0, idx_q} == grp_q.cnt - 3'd1);
  assign free_o    = !valid_q || (out_o.ready && last_beat);

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = grp_q.bytes[idx_q];
  assign out_o.is_error   = grp_q.is_error;
  assign out_o.fault_code = grp_q.fault;
  assign out_o.run_last   = last_beat;
  assign out_o.text_done  = last_beat & grp_q.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_o.ready) begin
      if (last_beat) valid_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_i;
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (grp_q.cnt != '0 && {1'b0, idx_q} < grp_q.cnt))
    else $error("result index outside group");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over pending results");

endmodule

// ===== rtl/core/xml_entity_unescape.sv =====
// channel   | dir | payload                                              | width
// ----------+-----+------------------------------------------------------+------
// in_i      | in  | in_byte, text_last                                   | 8+1
// out_o     | out | out_byte, is_error, fault_code, run_last, text_done  | 8+4
//
// one input byte is registered, decoded combinationally and its result group (one to
// four bytes) lands in the output register; a byte with a single result moves every
// cycle while out_o is ready; an n-byte UTF-8 group stalls in_i if the next byte has results
// bytes that produce no result (name bytes, dropped bytes) never wait on the output side
// rst_ni clears the reference and drop state and empties both registers at once
// a stall on out_o propagates combinationally to in_i.ready once both registers are full
module xml_entity_unescape #(
  parameter int unsigned MaxRefSpan = xeu_pkg::MaxRefSpanDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xeu_in_if.sink    in_i,
  xeu_out_if.source out_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  xeu_pkg::grp_t grp;
  logic          free;
  logic          step;
  logic          load;

  // the held byte advances when its results fit, or when it has none
  assign step = s1_valid_q && (grp.cnt == '0 || free);
  assign load = step && (grp.cnt != '0);

  // take a new transfer whenever the input register empties this cycle
  assign in_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.text_last;
    end
  end

  // reference tracking, name match, digit accumulation and UTF-8 encoding
  xeu_core #(
    .MaxRefSpan (MaxRefSpan)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_byte_i   (s1_byte_q),
    .text_last_i (s1_last_q),
    .grp_o       (grp)
  );

  // result register, emits the group one byte per transfer
  xeu_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .grp_i  (grp),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

localparam int unsigned NameDepth = xeu_pkg::MaxRefSpanDef - 1;

// one decoded result as it leaves the block
typedef struct packed {
  logic [7:0]      out_byte;
  logic            is_error;
  xeu_pkg::fault_e fault;
  logic            run_last;
  logic            text_done;
} dec_res_t;

class decode_checker;
  bit              in_ref;
  int unsigned     name_len;
  logic [7:0]      name_buf [NameDepth];
  bit              dropping;
  dec_res_t        group[$];
  dec_res_t        decoded_q[$];
  int unsigned     fails;
  int unsigned     taken;
  int unsigned     live;

  function void clear();
    in_ref   = 1'b0;
    name_len = 0;
    dropping = 1'b0;
  endfunction

  function void emit(logic [7:0] b);
    dec_res_t r;
    r = '0;
    r.out_byte = b;
    group = {group, r};
  endfunction

  function bit name_is(string s);
    if (name_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (name_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function int digit_of(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (!hex) return -1;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function void utf8_encode(int unsigned cp);
    if (cp < 'h80) begin
      emit(8'(cp));
    end else if (cp < 'h800) begin
      emit(8'('hC0 | (cp >> 6)));
      emit(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      emit(8'('hE0 | (cp >> 12)));
      emit(8'('h80 | ((cp >> 6) & 'h3F)));
      emit(8'('h80 | (cp & 'h3F)));
    end else begin
      emit(8'('hF0 | (cp >> 18)));
      emit(8'('h80 | ((cp >> 12) & 'h3F)));
      emit(8'('h80 | ((cp >> 6) & 'h3F)));
      emit(8'('h80 | (cp & 'h3F)));
    end
  endfunction

  // returns 1 when the held name is refused
  function bit resolve(output xeu_pkg::fault_e code);
    bit          hex;
    int unsigned first;
    int unsigned cp;
    int          d;
    code = xeu_pkg::FaultName;
    if (name_is("lt"))   begin emit("<");   return 1'b0; end
    if (name_is("gt"))   begin emit(">");   return 1'b0; end
    if (name_is("amp"))  begin emit("&");   return 1'b0; end
    if (name_is("quot")) begin emit(8'h22); return 1'b0; end
    if (name_is("apos")) begin emit(8'h27); return 1'b0; end
    if (name_len == 0 || name_buf[0] != "#") return 1'b1;
    code  = xeu_pkg::FaultNumeric;
    hex   = name_len > 2 && (name_buf[1] == "x" || name_buf[1] == "X");
    first = hex ? 2 : 1;
    if (first >= name_len) return 1'b1;
    cp = 0;
    for (int unsigned i = first; i < name_len; i++) begin
      d = digit_of(name_buf[i], hex);
      if (d < 0) return 1'b1;
      cp = cp * (hex ? 16 : 10) + d;
      if (cp > xeu_pkg::LastCp) return 1'b1;
    end
    utf8_encode(cp);
    return 1'b0;
  endfunction

  function void decode_byte(logic [7:0] b, logic last);
    bit              failed;
    xeu_pkg::fault_e code;
    int unsigned     n;
    taken++;
    group.delete();
    failed = 1'b0;
    code   = xeu_pkg::FaultName;
    if (dropping) begin
      if (last) clear();
      return;
    end
    live++;
    if (!in_ref) begin
      if (b == "&") begin
        in_ref   = 1'b1;
        name_len = 0;
        failed   = last;
      end else begin
        emit(b);
      end
    end else if (b == ";") begin
      failed   = resolve(code);
      in_ref   = 1'b0;
      name_len = 0;
    end else if (name_len >= NameDepth) begin
      failed = 1'b1;
      code   = (name_buf[0] == "#") ? xeu_pkg::FaultNumeric : xeu_pkg::FaultName;
    end else begin
      name_buf[name_len] = b;
      name_len++;
      failed = last;
      code   = (name_buf[0] == "#") ? xeu_pkg::FaultNumeric : xeu_pkg::FaultName;
    end
    if (failed) begin
      group.delete();
      emit(8'h00);
      group[0].is_error = 1'b1;
      group[0].fault    = code;
      in_ref   = 1'b0;
      name_len = 0;
      dropping = !last;
    end
    n = group.size();
    if (n > 0) begin
      group[n-1].run_last  = 1'b1;
      group[n-1].text_done = last || failed;
    end
    if (last) clear();
    decoded_q = {decoded_q, group};
  endfunction

  function void report(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    fails++;
  endfunction

  function void check_result(dec_res_t got);
    dec_res_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t ns: result with nothing expected, expected none, actual byte %02h error %0b",
               $time, got.out_byte, got.is_error);
      fails++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte)   report("out_byte", want.out_byte, got.out_byte);
    if (got.is_error !== want.is_error)   report("is_error", want.is_error, got.is_error);
    if (got.fault !== want.fault)         report("fault_code", want.fault, got.fault);
    if (got.run_last !== want.run_last)   report("run_last", want.run_last, got.run_last);
    if (got.text_done !== want.text_done) report("text_done", want.text_done, got.text_done);
  endfunction
endclass

module tb;

  logic clk_i = 1'b0;
  logic rst_ni;

  xeu_in_if  in_if ();
  xeu_out_if out_if ();

  xml_entity_unescape DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  decode_checker sb = new;

  // bytes of the text being assembled, and sender burst state
  logic [7:0]  text_q[$];
  int unsigned burst_left = 0;
  bit          held = 1'b0;
  string       ents [5] = '{"lt", "gt", "amp", "quot", "apos"};

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // both channels are observed at the same edge at which the transfer happens
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.decode_byte(in_if.in_byte, in_if.text_last);
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_byte:  out_if.out_byte,
                          is_error:  out_if.is_error,
                          fault:     xeu_pkg::fault_e'(out_if.fault_code),
                          run_last:  out_if.run_last,
                          text_done: out_if.text_done});
      end
    end
  end

  // one byte offered until its transfer; a new burst may start with an idle gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.text_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // the assembled text goes out with text_last on its final byte
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_letters(input int unsigned n);
    repeat (n) add_byte(8'($urandom_range(int'("a"), int'("z"))));
  endtask

  // numeric reference of random length class, decimal or hex, maybe zero padded
  task automatic add_numeric(input bit overflow);
    int unsigned cp;
    int unsigned room;
    int unsigned pad;
    bit          hex;
    string       digits;
    logic [7:0]  c;
    case ($urandom_range(0, 3))
      0:       cp = $urandom_range(0, 'h7F);
      1:       cp = $urandom_range('h80, 'h7FF);
      2:       cp = $urandom_range('h800, 'hFFFF);
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    if (overflow) cp = $urandom_range('h110000, 'hFFFFFF);
    hex    = 1'($urandom_range(0, 1));
    digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
    room   = NameDepth - (hex ? 2 : 1) - digits.len();
    pad    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, room) : 0;
    add_str("&#");
    if (hex) begin
      c = "x";
      if ($urandom_range(0, 1)) c = "X";
      add_byte(c);
    end
    repeat (pad) add_byte("0");
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      // hex digits in mixed case
      if (hex && c >= "a" && $urandom_range(0, 1)) c = c - 8'd32;
      add_byte(c);
    end
    add_byte(";");
  endtask

  // malformed and refused references
  task automatic add_broken();
    logic [7:0] c;
    case ($urandom_range(0, 8))
      0: begin
        add_str("&");
        add_letters($urandom_range(1, 4));
        add_str(";");
      end
      1: add_str("&;");
      2: add_str("&#;");
      3: add_str($urandom_range(0, 1) ? "&#x;" : "&#X;");
      4: begin
        // digit string broken by an arbitrary byte
        add_str("&#1");
        add_byte(8'($urandom_range(0, 255)));
        add_str(";");
      end
      5: begin
        // name as long as the reference span allows, or longer
        add_str($urandom_range(0, 1) ? "&#" : "&");
        repeat (NameDepth) begin
          c = 8'($urandom_range(0, 255));
          if (c == ";") c = "z";
          add_byte(c);
        end
      end
      6: add_numeric(1'b1);
      7: begin
        // opened but not closed here
        add_str("&");
        add_letters($urandom_range(0, 3));
      end
      default: begin
        add_str("&");
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
        add_str(";");
      end
    endcase
  endtask

  // mostly well-formed text: plain bytes, named and numeric references
  task automatic build_text();
    int unsigned pick;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        add_str({"&", ents[$urandom_range(0, 4)], ";"});
      end else if (pick < 85) begin
        add_numeric(1'b0);
      end else begin
        add_broken();
      end
    end
    // sometimes the text ends inside a reference
    if ($urandom_range(0, 7) == 0) begin
      add_str("&");
      add_letters($urandom_range(0, 2));
    end
  endtask

  // receiver: stretches of always ready, coin flips and periodic stalls,
  // plus one long hold-off while the sender keeps offering
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned phase;
    out_if.ready = 1'b0;
    phase = 0;
    forever begin
      if (!held && sb.taken >= 150) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        held = 1'b1;
      end
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(10, 60);
      period = $urandom_range(2, 5);
      repeat (span) begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= (phase % period) != 0;
        endcase
        phase++;
        @(posedge clk_i);
      end
    end
  end

  // main sequence
  initial begin
    int unsigned base;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_byte   = 8'h00;
    in_if.text_last = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: byte extremes, a named reference and a numeric one into a four byte sequence,
    // empty number, text ending right after the ampersand, unknown name then drop
    text_q = '{8'h00, 8'hFF};
    send_text();
    add_str("&apos;&#X1F600;");
    send_text();
    add_str("&#;");
    send_text();
    add_str("&");
    send_text();
    add_str("&x;A");
    send_text();

    // random texts until enough bytes were actually decoded
    base = sb.live;
    while (sb.live - base < 400) begin
      build_text();
      send_text();
    end
    in_if.valid <= 1'b0;

    // drain, then keep watching for anything unexpected
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
